// File: rtl/core/lenient_utf8_decoder_top_assert.svh
// Assertion macros shared by the lenient UTF-8 decoder RTL.
`ifndef LENIENT_UTF8_DECODER_TOP_ASSERT_SVH
`define LENIENT_UTF8_DECODER_TOP_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define LUD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define LUD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define LUD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/lud_pkg.sv
// Package with the result type, shift unit opcodes and byte constants of the decoder.
package lud_pkg;

    localparam int CP_W  = 31;
    localparam int CNT_W = 3;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [CNT_W-1:0] byte_count;
        logic             last;
    } result_t;

    typedef enum logic {
        OP_TRAIL,
        OP_LEAD
    } shift_op_t;

    localparam logic [7:0] TRAIL_MASK   = 8'hC0;
    localparam logic [7:0] TRAIL_TAG    = 8'h80;
    localparam logic [7:0] PAYLOAD_MASK = 8'h3F;
    localparam logic [7:0] LEAD2_MIN    = 8'hC0;
    localparam logic [7:0] LEAD3_MIN    = 8'hE0;
    localparam logic [7:0] LEAD4_MIN    = 8'hF0;
    localparam logic [7:0] LEAD5_MIN    = 8'hF8;
    localparam logic [7:0] LEAD6_MIN    = 8'hFC;
    localparam logic [7:0] SINGLE_MIN   = 8'hFE;

endpackage

// File: rtl/core/lud_shift_unit.sv
// Shared shift and mask unit that builds the code point accumulator.
module lud_shift_unit (
    input  lud_pkg::shift_op_t         op,
    input  logic [lud_pkg::CP_W-1:0]   acc_in,
    input  logic [7:0]                 byte_in,
    input  logic [2:0]                 seq_len,
    output logic [lud_pkg::CP_W-1:0]   value
);
    import lud_pkg::*;

    logic [2:0] lead_shift;
    logic [7:0] lead_bits;

    assign lead_shift = 3'(seq_len - 3'd1);
    assign lead_bits  = byte_in & (PAYLOAD_MASK >> lead_shift);

    always_comb
    begin
        unique case (op)
            OP_TRAIL: value = {acc_in[CP_W-7:0], byte_in[5:0]};
            OP_LEAD:  value = CP_W'(lead_bits);
            default:  value = '0;
        endcase
    end

endmodule

// File: rtl/core/lud_out_stage.sv
// Output register that holds one result item until the consumer takes it.
module lud_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lud_pkg::result_t push_data,
    output logic             free,
    output logic             out_valid,
    input  logic             out_ready,
    output lud_pkg::result_t out_data
);
    import lud_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // The slot may be refilled in the same cycle its item leaves.
    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= push_data;
        end
    end

endmodule

// File: rtl/core/lenient_utf8_decoder_top.sv
// Top level of the lenient UTF-8 decoder: sequencer, sequence state and pending trail store.
//
// The decoder takes one byte item at a time and returns code point items. Bytes below
// 0xC0 and the bytes 0xFE and 0xFF stand for themselves; lead bytes open sequences of
// two to MAX_SEQ_BYTES bytes, and leads of longer sequences stand for themselves. No
// overlong or surrogate checks are made. When a byte that is not a trail byte, or a
// flush item, arrives while a sequence is open, the lead byte and every trail byte
// taken so far come out one by one as themselves with a byte count of one, and the
// interrupting byte is then decoded afresh. The last flag marks the final result that
// an input item causes; an item that opens or continues a sequence causes none. Each
// item is taken in S_IDLE and evaluated in S_EVAL through the shared shift unit; the
// bytes of an interrupted sequence are then replayed one by one in S_REPLAY and,
// unless the item is a flush, the interrupting byte is decoded afresh in S_FRESH. The
// sequencer handles one item at a time, and a result waiting in the output register
// stalls it only when the next result is ready before the consumer has taken it. The
// decoder takes the next item while its last result still waits in the output register.
`include "lenient_utf8_decoder_top_assert.svh"

module lenient_utf8_decoder_top #(
    parameter int MAX_SEQ_BYTES = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_ready,
    input  logic [7:0]  data_byte,
    input  logic        flush,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [30:0] code_point,
    output logic [2:0]  byte_count,
    output logic        last
);
    import lud_pkg::*;

    // The pending store holds every trail byte but the one that completes a sequence.
    localparam int PEND_DEPTH = MAX_SEQ_BYTES - 2;
    localparam int PEND_AW    = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_REPLAY,
        S_FRESH
    } state_t;

    // Sequence length of a byte under the configured limit; 1 means it stands alone.
    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] n;
        begin
            if (b < LEAD2_MIN)
            begin
                n = 3'd1;
            end
            else if (b < LEAD3_MIN)
            begin
                n = 3'd2;
            end
            else if (b < LEAD4_MIN)
            begin
                n = 3'd3;
            end
            else if (b < LEAD5_MIN)
            begin
                n = (MAX_SEQ_BYTES > 3) ? 3'd4 : 3'd1;
            end
            else if (b < LEAD6_MIN)
            begin
                n = (MAX_SEQ_BYTES > 4) ? 3'd5 : 3'd1;
            end
            else if (b < SINGLE_MIN)
            begin
                n = (MAX_SEQ_BYTES > 5) ? 3'd6 : 3'd1;
            end
            else
            begin
                n = 3'd1;
            end
            return n;
        end
    endfunction

    state_t          state_reg, state_next;
    logic [7:0]      byte_reg, byte_next;
    logic            flush_reg, flush_next;
    logic [7:0]      lead_reg, lead_next;
    logic [2:0]      needed_reg, needed_next;
    logic [2:0]      seen_reg, seen_next;
    logic [CP_W-1:0] acc_reg, acc_next;
    logic [2:0]      idx_reg, idx_next;

    logic [7:0]      pend_mem [PEND_DEPTH];
    logic            pend_we;
    logic [2:0]      pend_rd;

    shift_op_t       unit_op;
    logic [CP_W-1:0] unit_value;
    logic [2:0]      fresh_len;
    logic            fresh_single;
    logic            seq_open;
    logic            is_trail;
    logic            do_fresh;
    logic [7:0]      replay_byte;

    logic            push;
    result_t         push_data;
    logic            out_free;
    result_t         out_data;

    assign data_ready   = (state_reg == S_IDLE);
    assign seq_open     = (needed_reg != 3'd0);
    assign is_trail     = ((byte_reg & TRAIL_MASK) == TRAIL_TAG);
    assign fresh_len    = seq_len(byte_reg);
    assign fresh_single = (fresh_len == 3'd1);

    // Replay slot zero is the lead byte; slot k is the k-th buffered trail byte.
    assign pend_rd     = 3'(idx_reg - 3'd1);
    assign replay_byte = (idx_reg == 3'd0) ? lead_reg : pend_mem[pend_rd[PEND_AW-1:0]];

    lud_shift_unit u_shift (
        .op      (unit_op),
        .acc_in  (acc_reg),
        .byte_in (byte_reg),
        .seq_len (fresh_len),
        .value   (unit_value)
    );

    lud_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .free      (out_free),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_data  (out_data)
    );

    assign code_point = out_data.code_point;
    assign byte_count = out_data.byte_count;
    assign last       = out_data.last;

    always_comb
    begin
        state_next  = state_reg;
        byte_next   = byte_reg;
        flush_next  = flush_reg;
        lead_next   = lead_reg;
        needed_next = needed_reg;
        seen_next   = seen_reg;
        acc_next    = acc_reg;
        idx_next    = idx_reg;
        pend_we     = 1'b0;
        unit_op     = OP_TRAIL;
        do_fresh    = 1'b0;
        push        = 1'b0;
        push_data   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (data_valid)
                begin
                    byte_next  = data_byte;
                    flush_next = flush;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (flush_reg)
                begin
                    idx_next   = 3'd0;
                    state_next = seq_open ? S_REPLAY : S_IDLE;
                end
                else if (seq_open && is_trail)
                begin
                    unit_op = OP_TRAIL;
                    if ((4'(seen_reg) + 4'd1) >= 4'(needed_reg))
                    begin
                        // The completing trail byte yields the decoded character.
                        if (out_free)
                        begin
                            push                 = 1'b1;
                            push_data.code_point = unit_value;
                            push_data.byte_count = 3'(needed_reg + 3'd1);
                            push_data.last       = 1'b1;
                            lead_next            = '0;
                            needed_next          = '0;
                            seen_next            = '0;
                            acc_next             = '0;
                            state_next           = S_IDLE;
                        end
                    end
                    else
                    begin
                        pend_we    = 1'b1;
                        seen_next  = 3'(seen_reg + 3'd1);
                        acc_next   = unit_value;
                        state_next = S_IDLE;
                    end
                end
                else if (seq_open)
                begin
                    idx_next   = 3'd0;
                    state_next = S_REPLAY;
                end
                else
                begin
                    do_fresh = 1'b1;
                end
            end
            S_REPLAY:
            begin
                if (out_free)
                begin
                    push                 = 1'b1;
                    push_data.code_point = CP_W'(replay_byte);
                    push_data.byte_count = 3'd1;
                    push_data.last       = (idx_reg == seen_reg) && (flush_reg || !fresh_single);
                    if (idx_reg == seen_reg)
                    begin
                        lead_next   = '0;
                        needed_next = '0;
                        seen_next   = '0;
                        acc_next    = '0;
                        state_next  = flush_reg ? S_IDLE : S_FRESH;
                    end
                    else
                    begin
                        idx_next = 3'(idx_reg + 3'd1);
                    end
                end
            end
            S_FRESH:
            begin
                do_fresh = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Fresh decode of a byte: it either stands alone or opens a new sequence.
        if (do_fresh)
        begin
            unit_op = OP_LEAD;
            if (fresh_single)
            begin
                if (out_free)
                begin
                    push                 = 1'b1;
                    push_data.code_point = CP_W'(byte_reg);
                    push_data.byte_count = 3'd1;
                    push_data.last       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            else
            begin
                lead_next   = byte_reg;
                needed_next = 3'(fresh_len - 3'd1);
                seen_next   = '0;
                acc_next    = unit_value;
                state_next  = S_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            byte_reg   <= '0;
            flush_reg  <= 1'b0;
            lead_reg   <= '0;
            needed_reg <= '0;
            seen_reg   <= '0;
            acc_reg    <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            byte_reg   <= byte_next;
            flush_reg  <= flush_next;
            lead_reg   <= lead_next;
            needed_reg <= needed_next;
            seen_reg   <= seen_next;
            acc_reg    <= acc_next;
            idx_reg    <= idx_next;
        end
    end

    // Buffered trail bytes need no reset: each is written before it is replayed.
    always_ff @(posedge clk)
    begin
        if (pend_we)
        begin
            pend_mem[seen_reg[PEND_AW-1:0]] <= byte_reg;
        end
    end

    // An open sequence has always taken fewer trail bytes than it needs.
    `LUD_ASSERT_ALWAYS(a_seen_below_needed,
        (needed_reg == 3'd0) || (seen_reg < needed_reg),
        "trail count reached the sequence length")

    // A result is only loaded when the output register can take it.
    `LUD_ASSERT_IMPL(a_push_into_free_slot, push, out_free, "result loaded over an untaken result")

    // An accepted item is always evaluated in the following cycle.
    `LUD_ASSERT_NEXT(a_accept_then_eval,
        data_valid && data_ready, state_reg == S_EVAL,
        "accepted item was not evaluated")

endmodule
